/* hdl/rrct_pkg.sv */
// Package for the read range check block: sizes, codes, request and result types.
// Holds the controller command and status structs and the trace record layout.
// Depends on nothing; the controller, datapath, top level and testbench import it.
`default_nettype none

package rrct_pkg;

    // Number of records held in the circular trace (2 to 256).
    localparam int TRACE_DEPTH = 16;

    localparam int SLOT_W = $clog2(TRACE_DEPTH);
    localparam int FILL_W = $clog2(TRACE_DEPTH + 1);
    localparam int TIDX_W = 8;
    localparam int CMP_W  = (FILL_W > TIDX_W) ? FILL_W : TIDX_W;
    localparam int BASE_W = SLOT_W + 2;

    // Slot of the sequence number that follows a 32-bit wrap, seen from slot zero.
    localparam logic [SLOT_W-1:0] SEQ_WRAP_SLOT =
        SLOT_W'((64'd1 << 32) % 64'(TRACE_DEPTH));
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TRACE_DEPTH - 1);
    localparam logic [BASE_W-1:0] DEPTH_B   = BASE_W'(TRACE_DEPTH);
    localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(TRACE_DEPTH);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_EN = 1'd1;

    // Request actions.
    typedef enum logic [1:0] {
        ACT_VALIDATE = 2'd0,
        ACT_READ     = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    // Check status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Trace record kinds.
    localparam logic [1:0] KIND_RECEIVED = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [1:0] KIND_REJECTED = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [31:0]       nsid;
        logic [63:0]       lba;
        logic [31:0]       blk_count;
        logic [TIDX_W-1:0] trace_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  check_status;
        logic        trace_hit;
        logic [31:0] rec_seq;
        logic [1:0]  rec_kind;
        logic [1:0]  rec_result;
        logic [31:0] rec_nsid;
        logic [63:0] rec_lba;
        logic [31:0] rec_blk_count;
    } rsp_t;

    // One trace record as stored in the trace RAM.
    typedef struct packed {
        logic [31:0] seq;
        logic [1:0]  kind;
        logic [1:0]  result;
        logic [31:0] nsid;
        logic [63:0] lba;
        logic [31:0] len;
    } rec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOG2,
        S_RD_ADDR,
        S_CLEAR,
        S_DONE
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic check;
        logic log_wr;
        logic log_second;
        logic rd_issue;
        logic clear;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] in_action;
        logic       trace_en;
        logic       out_free;
    } ctrl_sts_t;

endpackage

`default_nettype wire

/* hdl/rrct_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module rrct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/rrct_ctrl.sv */
// Controller of the read range check block: sequences one request at a time.
// Depends on rrct_pkg for the state, action and command/status types.
`default_nettype none

module rrct_ctrl
    import rrct_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ctrl_sts_t sts,
    output ctrl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    unique case (action_t'(sts.in_action))
                        ACT_VALIDATE: state_next = S_CHECK;
                        ACT_READ:     state_next = S_RD_ADDR;
                        ACT_CLEAR:    state_next = S_CLEAR;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_CHECK: begin
                // The status is resolved while the received record is logged.
                cmd.check = 1'b1;
                if (sts.trace_en) begin
                    cmd.log_wr = 1'b1;
                    state_next = S_LOG2;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_LOG2: begin
                cmd.log_wr     = 1'b1;
                cmd.log_second = 1'b1;
                state_next     = S_DONE;
            end
            S_RD_ADDR: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_DONE;
            end
            S_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/rrct_dpath.sv */
// Datapath of the read range check block: configuration, range check, trace
// pointers, trace RAM and the output register. Uses rrct_pkg and rrct_ram.
`default_nettype none

module rrct_dpath
    import rrct_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire req_t                  s_req,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output rsp_t                       m_rsp,
    input  wire ctrl_cmd_t             cmd,
    output ctrl_sts_t                  sts
);

    logic [63:0]       cap_reg;
    logic              trace_en_reg;
    req_t              req_reg;
    logic [64:0]       sum_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [31:0]       next_seq_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [SLOT_W-1:0] wr_slot_reg;
    logic [TRACE_DEPTH-1:0] valid_reg;
    logic              in_range_reg;
    logic              rd_valid_reg;
    logic [31:0]       rd_seq_reg;
    logic              m_valid_reg;
    rsp_t              m_rsp_reg;
    rsp_t              rsp_next;

    rec_t              log_rec;
    rec_t              ram_rdata;
    rec_t              stored;

    logic              rd_in_range;
    logic [FILL_W-1:0] rd_offset;
    logic [31:0]       rd_seq;
    logic              rd_borrow;
    logic [BASE_W-1:0] rd_base;
    logic [BASE_W-1:0] rd_off_b;
    logic [SLOT_W-1:0] rd_slot;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= '0;
            trace_en_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CAPACITY: cap_reg      <= cfg_wdata;
                CFG_TRACE_EN: trace_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Request capture; the end address is formed here so the compare stands alone.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_req;
            sum_reg <= {1'b0, s_req.lba} + 65'(s_req.blk_count);
        end
    end

    // Argument and range check.
    always_comb begin
        if (req_reg.nsid == '0 || req_reg.blk_count == '0) begin
            status_next = ST_INVALID;
        end else if (sum_reg[64] || sum_reg[63:0] > cap_reg) begin
            status_next = ST_RANGE;
        end else begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            status_reg <= status_next;
        end
    end

    // Record to log: the received record carries an ok result, the second
    // record carries the final status.
    always_comb begin
        log_rec.seq  = next_seq_reg;
        log_rec.nsid = req_reg.nsid;
        log_rec.lba  = req_reg.lba;
        log_rec.len  = req_reg.blk_count;
        if (cmd.log_second) begin
            log_rec.kind   = (status_reg == ST_OK) ? KIND_ACCEPTED : KIND_REJECTED;
            log_rec.result = status_reg;
        end else begin
            log_rec.kind   = KIND_RECEIVED;
            log_rec.result = ST_OK;
        end
    end

    // Trace pointers and per-slot valid bits. The write slot follows
    // next_seq modulo the depth, restarting at slot zero when next_seq wraps.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            next_seq_reg <= '0;
            fill_reg     <= '0;
            wr_slot_reg  <= '0;
            valid_reg    <= '0;
        end else if (cmd.log_wr) begin
            next_seq_reg           <= next_seq_reg + 32'd1;
            valid_reg[wr_slot_reg] <= 1'b1;
            if (next_seq_reg == '1 || wr_slot_reg == LAST_SLOT) begin
                wr_slot_reg <= '0;
            end else begin
                wr_slot_reg <= wr_slot_reg + SLOT_W'(1);
            end
            if (fill_reg != FILL_MAX) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    // Trace read address: expected sequence is next_seq - (fill - index),
    // and its slot is derived from the write slot with one wrap correction.
    always_comb begin
        rd_in_range = CMP_W'(req_reg.trace_index) < CMP_W'(fill_reg);
        rd_offset   = FILL_W'(CMP_W'(fill_reg) - CMP_W'(req_reg.trace_index));
        rd_seq      = next_seq_reg - 32'(rd_offset);
        rd_borrow   = next_seq_reg < 32'(rd_offset);
        rd_off_b    = BASE_W'(rd_offset);
        if (rd_borrow) begin
            rd_base = BASE_W'(SEQ_WRAP_SLOT) + BASE_W'(wr_slot_reg);
        end else begin
            rd_base = BASE_W'(wr_slot_reg);
        end
        if (rd_base >= rd_off_b) begin
            rd_slot = SLOT_W'(rd_base - rd_off_b);
        end else begin
            rd_slot = SLOT_W'(rd_base + DEPTH_B - rd_off_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            in_range_reg <= rd_in_range;
            rd_valid_reg <= rd_in_range && valid_reg[rd_slot];
            rd_seq_reg   <= rd_seq;
        end
    end

    rrct_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (TRACE_DEPTH)
    ) u_trace_ram (
        .aclk  (aclk),
        .we    (cmd.log_wr),
        .waddr (wr_slot_reg),
        .wdata (log_rec),
        .re    (cmd.rd_issue),
        .raddr (rd_slot),
        .rdata (ram_rdata)
    );

    // Result assembly; a slot never written since clear reads as zero.
    always_comb begin
        rsp_next = '0;
        stored   = rd_valid_reg ? ram_rdata : '0;
        case (req_reg.action)
            ACT_VALIDATE: rsp_next.check_status = status_reg;
            ACT_READ: begin
                if (in_range_reg) begin
                    rsp_next.trace_hit     = (stored.seq == rd_seq_reg);
                    rsp_next.rec_seq       = stored.seq;
                    rsp_next.rec_kind      = stored.kind;
                    rsp_next.rec_result    = stored.result;
                    rsp_next.rec_nsid      = stored.nsid;
                    rsp_next.rec_lba       = stored.lba;
                    rsp_next.rec_blk_count = stored.len;
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_rsp_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    // Status back to the controller.
    assign sts.in_action = s_req.action;
    assign sts.trace_en  = trace_en_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("trace fill count exceeds the trace depth");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (fill_reg == '0 && next_seq_reg == '0 && valid_reg == '0))
        else $error("clear did not empty the trace");

    a_log_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.log_wr && !cmd.log_second) |=> (cmd.log_wr && cmd.log_second))
        else $error("received record not followed by its verdict record");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

/* hdl/read_range_check_with_trace.sv */
// Read range check with circular trace.
// Input channel s_valid/s_ready carries one request (s_req): validate a read
// command, read a trace record at an offset from the oldest, or clear the trace.
// Result channel m_valid/m_ready carries exactly one result (m_rsp) per request.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 namespace
// capacity, 1 trace enable) in the same cycle; the user must write only while no
// request is open, as the block does not enforce it. A traced validate does the
// check and two record writes through the single trace RAM write port; an untraced
// validate, a trace read (registered RAM read) or a clear passes its own state;
// an unused action only hands over its result. One request is worked on at a time:
// a new request is taken only once the last result is handed over; s_ready is high
// while the controller is idle, even while a finished result waits in the output
// register. A stalled receiver holds the result in the output register; the next
// request then stops at the point of handing over its result until the register
// frees. Reset (synchronous, aresetn low) empties the trace, sets capacity to 0 and
// enables tracing; no clearing pass is needed since per-slot valid bits reset.
`default_nettype none

module read_range_check_with_trace
    import rrct_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire req_t                  s_req,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output rsp_t                       m_rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    rrct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rrct_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_req     (s_req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for read_range_check_with_trace: streams read-check,
// trace-read and clear requests and checks every result against its own model.
// Depends on rrct_pkg and the block's RTL only.

module testbench;
    import rrct_pkg::*;

    // Cycles without any request or result moving before the run is abandoned.
    localparam int IDLE_LIMIT = 2000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    req_t                  s_req = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    rsp_t                  m_rsp;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Model of the registers and of the circular trace.
    logic [63:0] capacity_reg;
    logic        trace_on;
    logic [31:0] seq_next;
    int          trace_fill;
    rec_t        trace_slots [TRACE_DEPTH];

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];

    int s_idle_pct = 0;
    int m_stall_pct = 0;
    int idle_cycles = 0;
    int error_count = 0;
    int n_requests = 0;
    int n_ok = 0;
    int n_invalid = 0;
    int n_range = 0;
    int n_hits = 0;
    int n_misses = 0;
    int n_clears = 0;

    read_range_check_with_trace u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_trace_model();
        seq_next = '0;
        trace_fill = 0;
        foreach (trace_slots[i]) trace_slots[i] = '0;
    endfunction

    // Appends one record at the slot of the next sequence number.
    function automatic void append_record(logic [1:0] kind, logic [1:0] result, req_t r);
        rec_t rec;
        rec.seq = seq_next;
        rec.kind = kind;
        rec.result = result;
        rec.nsid = r.nsid;
        rec.lba = r.lba;
        rec.len = r.blk_count;
        trace_slots[int'(seq_next % 32'(TRACE_DEPTH))] = rec;
        seq_next = seq_next + 32'd1;
        if (trace_fill < TRACE_DEPTH) trace_fill++;
    endfunction

    // Works out the result of one request and updates the trace model.
    function automatic rsp_t predict_result(req_t r);
        rsp_t        rsp = '0;
        logic [64:0] read_end;
        logic [31:0] seq;
        rec_t        rec;
        case (action_t'(r.action))
            ACT_VALIDATE: begin
                if (trace_on) append_record(KIND_RECEIVED, ST_OK, r);
                read_end = {1'b0, r.lba} + {33'd0, r.blk_count};
                if (r.nsid == '0 || r.blk_count == '0) begin
                    rsp.check_status = ST_INVALID;
                    n_invalid++;
                end else if (read_end[64] || read_end[63:0] > capacity_reg) begin
                    rsp.check_status = ST_RANGE;
                    n_range++;
                end else begin
                    rsp.check_status = ST_OK;
                    n_ok++;
                end
                if (trace_on) begin
                    append_record(rsp.check_status == ST_OK ? KIND_ACCEPTED : KIND_REJECTED,
                                  rsp.check_status, r);
                end
            end
            ACT_READ: begin
                // Offsets count from the oldest stored record; past the fill gives zeros.
                if (int'(r.trace_index) < trace_fill) begin
                    seq = seq_next - 32'(trace_fill) + 32'(r.trace_index);
                    rec = trace_slots[int'(seq % 32'(TRACE_DEPTH))];
                    rsp.trace_hit = (rec.seq == seq);
                    rsp.rec_seq = rec.seq;
                    rsp.rec_kind = rec.kind;
                    rsp.rec_result = rec.result;
                    rsp.rec_nsid = rec.nsid;
                    rsp.rec_lba = rec.lba;
                    rsp.rec_blk_count = rec.len;
                    n_hits++;
                end else begin
                    n_misses++;
                end
            end
            ACT_CLEAR: begin
                clear_trace_model();
                n_clears++;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    function automatic void push_req(action_t act, logic [31:0] nsid, logic [63:0] lba,
                                     logic [31:0] len, logic [7:0] tidx);
        req_t r;
        r.action = act;
        r.nsid = nsid;
        r.lba = lba;
        r.blk_count = len;
        r.trace_index = tidx;
        pending_reqs.push_back(r);
    endfunction

    // Random request, shaped so that checks straddle the capacity and most
    // trace reads land inside or just past the stored records.
    function automatic req_t random_req();
        req_t r;
        int   pick;
        r.nsid = $urandom;
        r.lba = {$urandom, $urandom};
        r.blk_count = $urandom;
        r.trace_index = 8'($urandom);
        pick = $urandom_range(99);
        r.action = (pick < 50) ? ACT_VALIDATE : (pick < 88) ? ACT_READ :
                   (pick < 94) ? ACT_CLEAR : ACT_NONE;
        if ($urandom_range(99) < 85) r.trace_index = 8'($urandom_range(TRACE_DEPTH + 2));
        pick = $urandom_range(9);
        if (pick == 0) r.nsid = '0;
        else if (pick == 1) r.nsid = '1;
        else if (pick < 6) r.nsid = $urandom_range(1, 16);
        pick = $urandom_range(9);
        if (pick == 0) r.blk_count = '0;
        else if (pick < 7) r.blk_count = $urandom_range(1, 256);
        case ($urandom_range(9))
            0, 1, 2: r.lba = capacity_reg - 64'(r.blk_count)
                             + 64'($urandom_range(2)) - 64'd1;
            3, 4: r.lba = 64'($urandom_range(4096));
            5: r.lba = ~64'd0 - 64'($urandom_range(300));
            default: ;
        endcase
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_CAPACITY) capacity_reg = value;
        else if (idx == CFG_TRACE_EN) trace_on = value[0];
    endtask

    // Holds until every request is sent and answered, then lets the block settle.
    // The queues are looked at between clock edges, once the driver has settled.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) pending_reqs.push_back(random_req());
        wait_idle();
    endtask

    // Request driver: predicts each request as it is accepted, then offers the next.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rsps.push_back(predict_result(s_req));
                n_requests++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                    s_req <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    error_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("check_status", 64'(want.check_status),
                                64'(m_rsp.check_status));
                    check_field("trace_hit", 64'(want.trace_hit), 64'(m_rsp.trace_hit));
                    check_field("rec_seq", 64'(want.rec_seq), 64'(m_rsp.rec_seq));
                    check_field("rec_kind", 64'(want.rec_kind), 64'(m_rsp.rec_kind));
                    check_field("rec_result", 64'(want.rec_result), 64'(m_rsp.rec_result));
                    check_field("rec_nsid", 64'(want.rec_nsid), 64'(m_rsp.rec_nsid));
                    check_field("rec_lba", want.rec_lba, m_rsp.rec_lba);
                    check_field("rec_blk_count", 64'(want.rec_blk_count),
                                64'(m_rsp.rec_blk_count));
                end
            end
            m_ready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles == IDLE_LIMIT) begin
                $display("Timed out after %0d cycles without a request or result", IDLE_LIMIT);
                $display("testbench: errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        capacity_reg = '0;
        trace_on = 1'b1;
        clear_trace_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks around a small capacity, with tracing on.
        write_reg(CFG_CAPACITY, 64'd1000);
        write_reg(CFG_TRACE_EN, 64'd1);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd0);
        push_req(ACT_NONE, '1, '1, '1, '1);
        push_req(ACT_VALIDATE, 32'd0, 64'd0, 32'd5, 8'd0);
        push_req(ACT_VALIDATE, 32'd7, 64'd0, 32'd0, 8'd0);
        push_req(ACT_VALIDATE, 32'd1, 64'd0, 32'd1000, 8'd0);
        push_req(ACT_VALIDATE, 32'd1, 64'd1, 32'd1000, 8'd0);
        push_req(ACT_VALIDATE, '1, 64'd0, '1, 8'd0);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd3);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd9);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd10);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd255);
        for (int i = 0; i < 4; i++) push_req(ACT_VALIDATE, 32'd2, 64'(i * 100), 32'd50, 8'd0);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd0);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd15);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd16);
        push_req(ACT_CLEAR, 32'd0, 64'd0, 32'd0, 8'd0);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd0);
        // The sender holds here until every result is back.
        wait_idle();

        // Largest capacity: a read that carries past 64 bits and one ending at the top.
        write_reg(CFG_CAPACITY, '1);
        push_req(ACT_VALIDATE, 32'd3, '1, 32'd1, 8'd0);
        push_req(ACT_VALIDATE, 32'd3, ~64'd5, 32'd5, 8'd0);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd1);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd3);
        wait_idle();

        // Zero capacity and tracing off: checks give a status but leave the trace alone.
        write_reg(CFG_CAPACITY, 64'd0);
        write_reg(CFG_TRACE_EN, 64'd0);
        push_req(ACT_VALIDATE, 32'd4, 64'd0, 32'd1, 8'd0);
        push_req(ACT_VALIDATE, 32'd0, 64'd0, 32'd1, 8'd0);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd0);
        push_req(ACT_READ, 32'd0, 64'd0, 32'd0, 8'd4);
        wait_idle();

        // Random traffic under four idling patterns and several register settings.
        write_reg(CFG_TRACE_EN, 64'd1);
        write_reg(CFG_CAPACITY, 64'd5000);
        run_random(110);

        write_reg(CFG_CAPACITY, '1);
        s_idle_pct = 57;
        run_random(110);

        write_reg(CFG_CAPACITY, {$urandom, $urandom});
        s_idle_pct = 0;
        m_stall_pct = 57;
        run_random(55);
        write_reg(CFG_TRACE_EN, 64'd0);
        run_random(55);

        write_reg(CFG_TRACE_EN, 64'd1);
        write_reg(CFG_CAPACITY, 64'h1_0000);
        s_idle_pct = 18;
        m_stall_pct = 18;
        run_random(110);

        repeat (8) @(posedge aclk);
        $display("Covered %0d requests: %0d in-range, %0d invalid and %0d out-of-range checks,",
                 n_requests, n_ok, n_invalid, n_range);
        $display("%0d trace reads inside the fill, %0d past it, and %0d clears.",
                 n_hits, n_misses, n_clears);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
